[hw/rtl/tdd_pkg.sv]
`timescale 1ns / 1ps
package tdd_pkg;

  localparam int QUOTIENT_WIDTH = 64;
  localparam int WORD_WIDTH     = 64;
  localparam int TARGET_WIDTH   = 4 * WORD_WIDTH;
  localparam int DIFF_WIDTH     = 64;

  typedef enum logic {
    MODE_BDIFF = 1'b0,
    MODE_PDIFF = 1'b1
  } mode_t;

  // 0xFFFF << 208 and 2^224 - 1
  localparam logic [TARGET_WIDTH-1:0] NUM_BDIFF = {32'h0, 16'hFFFF, 208'h0};
  localparam logic [TARGET_WIDTH-1:0] NUM_PDIFF = {32'h0, {224{1'b1}}};

  // part of the numerator above the quotient bits; the bits below are all equal to the mode
  localparam logic [TARGET_WIDTH-1:0] NUM_BDIFF_HI = NUM_BDIFF >> QUOTIENT_WIDTH;
  localparam logic [TARGET_WIDTH-1:0] NUM_PDIFF_HI = NUM_PDIFF >> QUOTIENT_WIDTH;

  typedef struct packed {
    logic [TARGET_WIDTH-1:0]   rem;
    logic [TARGET_WIDTH-1:0]   den;
    logic [QUOTIENT_WIDTH-1:0] quo;
    mode_t                     mode;
    logic                      sat;
    logic                      dz;
  } stage_t;

  typedef struct packed {
    logic [DIFF_WIDTH-1:0] difficulty;
    logic                  saturated;
    logic                  divide_by_zero;
  } result_t;

endpackage

[hw/rtl/target_to_difficulty_divider.sv]
`timescale 1ns / 1ps
// Difficulty from a 256-bit target: difficulty = floor(numerator / target), where
// difficulty_mode picks 0xFFFF << 208 (0) or 2^224 - 1 (1). The block accepts one
// target (four words) per cycle while in_stall is low: an entry stage checks for
// a zero target and for overflow, then a chain of QUOTIENT_WIDTH division cells,
// each one 258-bit subtract, forms one quotient bit apiece, and a two-deep output
// buffer absorbs stalls. A zero target gives 0 with divide_by_zero set; an
// overflowing quotient gives all ones with saturated set.
// Write difficulty_mode only while no word is in flight.
module target_to_difficulty_divider (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write_enable,
  input  logic                             cfg_write_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [tdd_pkg::WORD_WIDTH-1:0]   target_word_0,
  input  logic [tdd_pkg::WORD_WIDTH-1:0]   target_word_1,
  input  logic [tdd_pkg::WORD_WIDTH-1:0]   target_word_2,
  input  logic [tdd_pkg::WORD_WIDTH-1:0]   target_word_3,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [tdd_pkg::DIFF_WIDTH-1:0]   difficulty,
  output logic                             saturated,
  output logic                             divide_by_zero
);

  localparam int Depth = tdd_pkg::QUOTIENT_WIDTH;

  tdd_pkg::mode_t   difficulty_mode;
  logic             en;
  logic             vld [0:Depth];
  tdd_pkg::stage_t  st  [0:Depth];
  tdd_pkg::result_t last_res;
  tdd_pkg::result_t out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      difficulty_mode <= tdd_pkg::MODE_BDIFF;
    end else if (cfg_write_enable) begin
      difficulty_mode <= tdd_pkg::mode_t'(cfg_write_data);
    end
  end

  assign in_stall = !en;

  tdd_entry u_entry (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .target    ({target_word_3, target_word_2, target_word_1, target_word_0}),
    .mode      (difficulty_mode),
    .out_valid (vld[0]),
    .out_stage (st[0])
  );

  for (genvar g = 0; g < Depth; g++) begin : g_cell
    tdd_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (vld[g]),
      .in_stage  (st[g]),
      .out_valid (vld[g+1]),
      .out_stage (st[g+1])
    );
  end

  always_comb begin
    last_res.saturated      = st[Depth].sat;
    last_res.divide_by_zero = st[Depth].dz;
    if (st[Depth].dz) begin
      last_res.difficulty = '0;
    end else if (st[Depth].sat) begin
      last_res.difficulty = tdd_pkg::DIFF_WIDTH'({tdd_pkg::QUOTIENT_WIDTH{1'b1}});
    end else begin
      last_res.difficulty = tdd_pkg::DIFF_WIDTH'(st[Depth].quo);
    end
  end

  tdd_out_skid u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vld[Depth]),
    .in_res    (last_res),
    .en        (en),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign difficulty     = out_res.difficulty;
  assign saturated      = out_res.saturated;
  assign divide_by_zero = out_res.divide_by_zero;

endmodule

[hw/rtl/tdd_entry.sv]
`timescale 1ns / 1ps
module tdd_entry (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic [tdd_pkg::TARGET_WIDTH-1:0]    target,
  input  tdd_pkg::mode_t                      mode,
  output logic                                out_valid,
  output tdd_pkg::stage_t                     out_stage
);

  logic [tdd_pkg::TARGET_WIDTH-1:0] num_hi;
  logic                             is_zero;
  logic                             too_big;

  always_comb begin
    num_hi  = (mode == tdd_pkg::MODE_PDIFF) ? tdd_pkg::NUM_PDIFF_HI : tdd_pkg::NUM_BDIFF_HI;
    is_zero = (target == '0);
    // quotient overflows exactly when target <= numerator >> quotient width
    too_big = !is_zero && (target <= num_hi);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en && in_valid) begin
      out_stage.rem  <= num_hi;
      out_stage.den  <= target;
      out_stage.quo  <= '0;
      out_stage.mode <= mode;
      out_stage.sat  <= too_big;
      out_stage.dz   <= is_zero;
    end
  end

endmodule

[hw/rtl/tdd_div_cell.sv]
`timescale 1ns / 1ps
module tdd_div_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  tdd_pkg::stage_t in_stage,
  output logic            out_valid,
  output tdd_pkg::stage_t out_stage
);

  logic [tdd_pkg::TARGET_WIDTH:0]   shifted;
  logic [tdd_pkg::TARGET_WIDTH+1:0] diff;
  logic                             take;
  tdd_pkg::stage_t                  stage_next;

  always_comb begin
    // bring in the next numerator bit, which equals the mode below the high part
    shifted = {in_stage.rem, (in_stage.mode == tdd_pkg::MODE_PDIFF)};
    diff    = {1'b0, shifted} - {2'b00, in_stage.den};
    take    = !diff[tdd_pkg::TARGET_WIDTH+1];
    stage_next     = in_stage;
    stage_next.rem = take ? diff[tdd_pkg::TARGET_WIDTH-1:0]
                          : shifted[tdd_pkg::TARGET_WIDTH-1:0];
    stage_next.quo = {in_stage.quo[tdd_pkg::QUOTIENT_WIDTH-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en && in_valid) begin
      out_stage <= stage_next;
    end
  end

endmodule

[hw/rtl/tdd_out_skid.sv]
`timescale 1ns / 1ps
module tdd_out_skid (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  tdd_pkg::result_t in_res,
  output logic             en,
  output logic             out_valid,
  input  logic             out_stall,
  output tdd_pkg::result_t out_res
);

  logic             skid_valid;
  tdd_pkg::result_t skid_res;

  assign en = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!skid_valid) begin
      if (in_valid) begin
        if (out_valid && out_stall) begin
          skid_valid <= 1'b1;
        end else begin
          out_valid <= 1'b1;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end else if (!out_stall) begin
      skid_valid <= 1'b0;
    end

    if (!skid_valid) begin
      if (in_valid) begin
        if (out_valid && out_stall) begin
          skid_res <= in_res;
        end else begin
          out_res <= in_res;
        end
      end
    end else if (!out_stall) begin
      out_res <= skid_res;
    end
  end

endmodule
